/* design/bst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the bencode stream tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int BST_MAX_DEPTH  = 64;
    localparam int BST_FIFO_DEPTH = 2;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [67:0] LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] LIMIT_NEG = 68'h0_8000_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_AWAIT = 2'd0,
        MODE_INT   = 2'd1,
        MODE_LEN   = 2'd2,
        MODE_DATA  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        TK_NONE   = 3'd0,
        TK_INT    = 3'd1,
        TK_LEN    = 3'd2,
        TK_BYTE   = 3'd3,
        TK_LIST   = 3'd4,
        TK_DICT   = 3'd5,
        TK_END    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [63:0] token_value;
        logic               is_key;
        logic [6:0]         nest_depth;
        logic [1:0]         parse_status;
    } t_out_word;

    typedef struct packed {
        logic any;
        logic lead0;
        logic body;
        logic neg;
        logic digit;
    } t_num_flags;

endpackage
`default_nettype wire

/* design/bst_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module bst_fifo #(
    parameter int W     = 9,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            // advance pointers, wrapping at the depth
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

/* design/bst_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bst_core
// Tokenizer back end: consumes one byte per cycle while a byte is waiting and the output has room, one token per byte.
// ----------------------------------------------------------------------------
module bst_core
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = BST_MAX_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    input  wire logic     i_out_ready,
    output logic          o_step,
    output t_out_word     o_word
);
    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // stack below the cached top entry: {kind, parity}
    logic [1:0]     r_stk [MAX_DEPTH];
    logic [1:0]     r_below;

    t_mode          r_mode, n_mode;
    logic [SPW-1:0] r_sp, n_sp;
    logic           r_top_kind, n_top_kind;
    logic           r_top_par, n_top_par;
    logic [63:0]    r_acc, n_acc;
    t_num_flags     r_flags, n_flags;
    logic [63:0]    r_rem, n_rem;
    logic           r_halted, n_halted;

    logic           st_we;
    logic [AW-1:0]  st_wa, st_ra;
    logic [1:0]     st_wd;

    logic [7:0]     b;
    logic           is_dig, is_ws;
    logic [67:0]    acc_next;
    logic           ovf;
    logic           err, done, ok, par_t;
    logic [63:0]    neg_val;

    assign o_step = i_valid && i_out_ready;
    assign b      = i_word.byte_in;
    assign is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign acc_next = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + 68'(b - CH_ZERO);
    assign neg_val  = 64'd0 - r_acc;

    always_comb begin
        n_mode     = r_mode;
        n_sp       = r_sp;
        n_top_kind = r_top_kind;
        n_top_par  = r_top_par;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_rem      = r_rem;
        n_halted   = r_halted;
        st_we      = 1'b0;
        st_wa      = AW'(r_sp - SPW'(1));
        st_wd      = {r_top_kind, r_top_par};
        err        = 1'b0;
        done       = 1'b0;
        ok         = 1'b1;
        par_t      = r_top_par;
        ovf        = 1'b0;
        o_word     = '0;
        o_word.nest_depth = 7'(r_sp);

        if (r_halted) begin
            o_word.nest_depth   = '0;
            o_word.parse_status = ST_IGNORED;
        end else begin
            unique case (r_mode)
                MODE_AWAIT: begin
                    // begin_value: check and toggle the open container's parity
                    if (r_sp != '0) begin
                        par_t = !r_top_par;
                    end
                    if (b == CH_I || b == CH_L || b == CH_D) begin
                        ok = !((r_sp != '0) && r_top_kind && !r_top_par);
                    end
                    if (b == CH_I) begin
                        if (!ok) begin
                            err = 1'b1;
                        end else begin
                            n_top_par = par_t;
                            n_mode    = MODE_INT;
                            n_acc     = '0;
                            n_flags   = '0;
                        end
                    end else if (b == CH_L || b == CH_D) begin
                        if (r_sp >= SPW'(MAX_DEPTH) || !ok) begin
                            err = 1'b1;
                        end else begin
                            st_we      = (r_sp != '0);
                            st_wd      = {r_top_kind, par_t};
                            n_top_kind = (b == CH_D);
                            n_top_par  = 1'b0;
                            n_sp       = r_sp + SPW'(1);
                            o_word.token_kind = (b == CH_D) ? TK_DICT : TK_LIST;
                        end
                    end else if (b == CH_E) begin
                        if (r_sp == '0 || (r_top_kind && r_top_par)) begin
                            err = 1'b1;
                        end else begin
                            n_sp       = r_sp - SPW'(1);
                            n_top_kind = r_below[1];
                            n_top_par  = r_below[0];
                            o_word.token_kind = TK_END;
                            done = (n_sp == '0);
                        end
                    end else if (is_dig) begin
                        n_top_par = par_t;
                        n_mode    = MODE_LEN;
                        n_acc     = 64'(b - CH_ZERO);
                    end
                end
                MODE_INT: begin
                    if (b == CH_E) begin
                        if (!r_flags.digit) begin
                            err = r_flags.any;
                        end else begin
                            err = (r_acc != '0) && r_flags.lead0;
                            o_word.token_value = r_flags.neg ? neg_val : r_acc;
                        end
                        if (err) begin
                            o_word.token_value = '0;
                        end else begin
                            o_word.token_kind = TK_INT;
                            n_mode = MODE_AWAIT;
                            done   = (r_sp == '0);
                        end
                    end else begin
                        if (!r_flags.any) begin
                            n_flags.any   = 1'b1;
                            n_flags.lead0 = (b == CH_ZERO);
                        end
                        if (is_ws) begin
                            err = r_flags.body;
                        end else if (b == CH_PLUS || b == CH_MINUS) begin
                            err = r_flags.body;
                            n_flags.body = 1'b1;
                            n_flags.neg  = (b == CH_MINUS);
                        end else if (is_dig) begin
                            n_flags.body  = 1'b1;
                            n_flags.digit = 1'b1;
                            ovf   = acc_next > (r_flags.neg ? LIMIT_NEG : LIMIT_POS);
                            err   = ovf;
                            n_acc = acc_next[63:0];
                        end else begin
                            err = 1'b1;
                        end
                    end
                end
                MODE_LEN: begin
                    if (is_dig) begin
                        err   = acc_next > LIMIT_POS;
                        n_acc = acc_next[63:0];
                    end else if (b == CH_COLON) begin
                        o_word.token_kind  = TK_LEN;
                        o_word.token_value = r_acc;
                        o_word.is_key      = (r_sp != '0) && r_top_kind && r_top_par;
                        if (r_acc == '0) begin
                            n_mode = MODE_AWAIT;
                            done   = (r_sp == '0);
                        end else begin
                            n_rem  = r_acc;
                            n_mode = MODE_DATA;
                        end
                    end else begin
                        err = 1'b1;
                    end
                end
                MODE_DATA: begin
                    o_word.token_kind  = TK_BYTE;
                    o_word.token_value = 64'(b);
                    o_word.is_key      = (r_sp != '0) && r_top_kind && r_top_par;
                    n_rem = r_rem - 64'd1;
                    if (n_rem == '0) begin
                        n_mode = MODE_AWAIT;
                        done   = (r_sp == '0);
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase

            if (err) begin
                o_word     = '0;
                o_word.nest_depth   = 7'(r_sp);
                o_word.parse_status = ST_ERROR;
                n_halted   = 1'b1;
                st_we      = 1'b0;
                n_sp       = r_sp;
            end else if (done) begin
                o_word.nest_depth   = 7'(n_sp);
                o_word.parse_status = ST_DONE;
                n_halted = 1'b1;
            end else begin
                o_word.nest_depth = 7'(n_sp);
                if (i_word.last_byte) begin
                    o_word.parse_status = ST_ERROR;
                end
            end
        end

        // last byte: start a new message
        if (i_word.last_byte) begin
            n_mode   = MODE_AWAIT;
            n_sp     = '0;
            n_acc    = '0;
            n_flags  = '0;
            n_rem    = '0;
            n_halted = 1'b0;
        end

        if (!o_step) begin
            n_mode     = r_mode;
            n_sp       = r_sp;
            n_top_kind = r_top_kind;
            n_top_par  = r_top_par;
            n_acc      = r_acc;
            n_flags    = r_flags;
            n_rem      = r_rem;
            n_halted   = r_halted;
            st_we      = 1'b0;
        end
        st_ra = AW'(n_sp - SPW'(2));
    end

    // stack memory; read the entry below the next top, forwarding a same-cycle write
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stk[st_wa] <= st_wd;
        end
        if (st_we && st_wa == st_ra) begin
            r_below <= st_wd;
        end else begin
            r_below <= r_stk[st_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_kind <= n_top_kind;
        r_top_par  <= n_top_par;
        if (!i_rst_n) begin
            r_mode   <= MODE_AWAIT;
            r_sp     <= '0;
            r_acc    <= '0;
            r_flags  <= '0;
            r_rem    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_sp     <= n_sp;
            r_acc    <= n_acc;
            r_flags  <= n_flags;
            r_rem    <= n_rem;
            r_halted <= n_halted;
        end
    end
endmodule
`default_nettype wire

/* design/bencode_stream_tokenizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bencode_stream_tokenizer_top
// Streaming bencode tokenizer: one message byte in, one token word out.
// ----------------------------------------------------------------------------
// Push one byte word per cycle while o_full is low; each byte yields exactly
// one token word on the output queue, read while o_empty is low and taken
// with i_pop. Sustained rate is one byte per cycle while the output queue is
// drained: the parse step (multiply by ten and add, stack push or pop) is
// combinational. A byte in the input queue is parsed straight out of it and
// its token is registered into the output queue once that queue has room.
// The container stack keeps its top entry in flops and the rest in a
// MAX_DEPTH-entry memory with one registered read of the entry below the top.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bencode_stream_tokenizer_top
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH  = BST_MAX_DEPTH,
    parameter int FIFO_DEPTH = BST_FIFO_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_word i_in_word,
    output logic          o_full,
    input  wire logic     i_pop,
    output t_out_word     o_out_word,
    output logic          o_empty
);
    t_in_word  q_word;
    t_out_word tok_word;
    logic      q_empty, out_full, step;

    // front: hold incoming bytes
    bst_fifo #(.W($bits(t_in_word)), .DEPTH(FIFO_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_in_word),
        .o_full  (o_full),
        .i_pop   (step),
        .o_data  (q_word),
        .o_empty (q_empty)
    );

    // back: parse one byte whenever a byte is queued and the output queue has room
    bst_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_word      (q_word),
        .i_out_ready (!out_full),
        .o_step      (step),
        .o_word      (tok_word)
    );

    // result queue decouples the consumer from the parser
    bst_fifo #(.W($bits(t_out_word)), .DEPTH(FIFO_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (tok_word),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_out_word),
        .o_empty (o_empty)
    );
endmodule
`default_nettype wire
